>>> rtl/sdu_pkg.sv
// Shared types and constants for the shadow-difference display updater.
// Depends on nothing; the top level and its submodules use it by scoped names.
`timescale 1ns / 1ps

package sdu_pkg;

   // Fixed field widths
   localparam int PIXEL_W  = 16;
   localparam int COLUMN_W = 10;
   localparam int LINE_W   = 9;
   localparam int BUS_W    = 16;
   // Width that holds any panel size or coordinate sum for compares
   localparam int LIMIT_W  = 11;

   // Reset value of the run length register
   localparam logic [COLUMN_W-1:0] RUN_LENGTH_RESET = 10'd40;

   // Panel command codes (low byte of the bus word)
   localparam logic [7:0] CMD_LINE_START = 8'h02;
   localparam logic [7:0] CMD_COL_START  = 8'h03;
   localparam logic [7:0] CMD_LINE_END   = 8'h06;
   localparam logic [7:0] CMD_COL_END    = 8'h07;
   localparam logic [7:0] CMD_MEM_WRITE  = 8'h0F;

   // Steps of the bus write sequence for one item
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LINE_START_CMD = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LINE_START_VAL = 4'd1;
   localparam logic [STEP_W-1:0] STEP_COL_START_CMD  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_COL_START_VAL  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LINE_END_CMD   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LINE_END_VAL   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_COL_END_CMD    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_COL_END_VAL    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MEM_WRITE_CMD  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_PIXEL          = 4'd9;

   // What the decision stage hands to the bus sequencer
   typedef struct packed {
      logic                full;      // window sequence before the pixel
      logic [LINE_W-1:0]   line;
      logic [COLUMN_W-1:0] column;
      logic [COLUMN_W-1:0] group_end;
      logic [PIXEL_W-1:0]  pixel;
   } burst_type;

endpackage

>>> rtl/sdu_shadow_store.sv
// Shadow frame store: one synchronous memory with a registered read port,
// one write port and a zeroing sweep after reset. Uses sdu_pkg.
`timescale 1ns / 1ps

module sdu_shadow_store #(
   parameter int DEPTH = 384000,
   parameter int AW    = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [sdu_pkg::PIXEL_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [sdu_pkg::PIXEL_W-1:0] wr_data,
   output logic                        clearing
);

   logic [sdu_pkg::PIXEL_W-1:0] shadow_mem_ff [DEPTH];
   logic [sdu_pkg::PIXEL_W-1:0] rd_data_ff;
   logic                        clr_busy_ff, clr_busy_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [sdu_pkg::PIXEL_W-1:0] mem_wdata;

   // Sweep every entry to zero once after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Sweep owns the write port while it runs
   assign mem_we    = clr_busy_ff | wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   // Read returns the old value on a same-cycle write; caller forwards
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= shadow_mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

>>> rtl/sdu_emitter.sv
// Bus write sequencer: turns one decided item into a window sequence and
// pixel write, or the pixel write alone. Uses sdu_pkg.
`timescale 1ns / 1ps

module sdu_emitter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_en,
   input  sdu_pkg::burst_type          load,
   output logic                        free,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_command,
   output logic [sdu_pkg::BUS_W-1:0]   rsp_bus_value,
   output logic                        rsp_last
);

   logic                             valid_ff, valid_in;
   logic [sdu_pkg::STEP_W-1:0]       step_ff, step_in;
   sdu_pkg::burst_type               burst_ff;
   logic                             done;

   // Last step taken this cycle
   assign done = valid_ff && !rsp_stall && (step_ff == sdu_pkg::STEP_PIXEL);
   assign free = !valid_ff || done;

   // Advance through the steps, reload when the previous burst ends
   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load_en) begin
         valid_in = 1'b1;
         step_in  = load.full ? sdu_pkg::STEP_LINE_START_CMD : sdu_pkg::STEP_PIXEL;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && !rsp_stall) begin
         step_in = step_ff + sdu_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= sdu_pkg::STEP_PIXEL;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         burst_ff <= load;
      end
   end

   // Drive the bus word for the current step
   always_comb begin
      rsp_is_command = 1'b0;
      rsp_bus_value  = '0;
      rsp_last       = 1'b0;
      case (step_ff)
         sdu_pkg::STEP_LINE_START_CMD: begin
            rsp_is_command = 1'b1;
            rsp_bus_value  = {8'h00, sdu_pkg::CMD_LINE_START};
         end
         sdu_pkg::STEP_LINE_START_VAL: begin
            rsp_bus_value = sdu_pkg::BUS_W'(burst_ff.line);
         end
         sdu_pkg::STEP_COL_START_CMD: begin
            rsp_is_command = 1'b1;
            rsp_bus_value  = {8'h00, sdu_pkg::CMD_COL_START};
         end
         sdu_pkg::STEP_COL_START_VAL: begin
            rsp_bus_value = sdu_pkg::BUS_W'(burst_ff.column);
         end
         sdu_pkg::STEP_LINE_END_CMD: begin
            rsp_is_command = 1'b1;
            rsp_bus_value  = {8'h00, sdu_pkg::CMD_LINE_END};
         end
         sdu_pkg::STEP_LINE_END_VAL: begin
            rsp_bus_value = sdu_pkg::BUS_W'(burst_ff.line);
         end
         sdu_pkg::STEP_COL_END_CMD: begin
            rsp_is_command = 1'b1;
            rsp_bus_value  = {8'h00, sdu_pkg::CMD_COL_END};
         end
         sdu_pkg::STEP_COL_END_VAL: begin
            rsp_bus_value = sdu_pkg::BUS_W'(burst_ff.group_end);
         end
         sdu_pkg::STEP_MEM_WRITE_CMD: begin
            rsp_is_command = 1'b1;
            rsp_bus_value  = {8'h00, sdu_pkg::CMD_MEM_WRITE};
         end
         sdu_pkg::STEP_PIXEL: begin
            rsp_bus_value = burst_ff.pixel;
            rsp_last      = 1'b1;
         end
         default: begin
            rsp_bus_value = '0;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

>>> rtl/shadow_diff_display_updater.sv
// Top level of the shadow-difference display updater: input pipeline,
// group tracking and run length register. Uses sdu_pkg, sdu_shadow_store, sdu_emitter.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one framebuffer pixel per item with its column and line.
//   rsp_ channel: panel bus writes; rsp_is_command marks a command byte,
//   rsp_last marks the final write caused by one input item.
//   csr_wr_en / csr_wr_data: write the run length; change it only while idle.
// Path: an item's first write is offered after stage 1 (address multiply,
//   shadow read), stage 2 (decision) and the load into the bus sequencer.
// Throughput: one item per cycle while items cause zero or one write and
//   rsp_stall is low. A pixel that opens a group holds the bus sequencer
//   until its pixel write, and the input stalls behind it. Pixels outside
//   the panel and unchanged pixels outside a group produce no write.
// Reset: after reset the shadow memory is zeroed one entry per cycle, all
//   PANEL_WIDTH * PANEL_HEIGHT entries (384000 at the default size); req_stall
//   stays high until that sweep ends. Run length resets to 40.
// Stall: rsp_stall holds the current write steady; the two pipeline stages
//   fill and then req_stall rises.
module shadow_diff_display_updater #(
   parameter int PANEL_WIDTH  = 800,
   parameter int PANEL_HEIGHT = 480
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sdu_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic [sdu_pkg::COLUMN_W-1:0] req_column,
   input  logic [sdu_pkg::LINE_W-1:0]   req_line,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_is_command,
   output logic [sdu_pkg::BUS_W-1:0]    rsp_bus_value,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [sdu_pkg::COLUMN_W-1:0] csr_wr_data
);

   localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [sdu_pkg::LIMIT_W-1:0] WIDTH_LIM  = sdu_pkg::LIMIT_W'(PANEL_WIDTH);
   localparam logic [sdu_pkg::LIMIT_W-1:0] HEIGHT_LIM = sdu_pkg::LIMIT_W'(PANEL_HEIGHT);
   localparam logic [sdu_pkg::LIMIT_W-1:0] LAST_COL   = sdu_pkg::LIMIT_W'(PANEL_WIDTH - 1);

   // Configuration
   logic [sdu_pkg::COLUMN_W-1:0] run_length_ff;

   // Stage 1: accepted item, address calculation and shadow read
   logic                         s1_valid_ff;
   logic [sdu_pkg::PIXEL_W-1:0]  s1_pixel_ff;
   logic [sdu_pkg::COLUMN_W-1:0] s1_column_ff;
   logic [sdu_pkg::LINE_W-1:0]   s1_line_ff;
   logic                         s1_inrange;
   logic [AW-1:0]                s1_addr;
   logic                         s1_adv;

   // Stage 2: decision and shadow write
   logic                         s2_valid_ff;
   logic [sdu_pkg::PIXEL_W-1:0]  s2_pixel_ff;
   logic [sdu_pkg::COLUMN_W-1:0] s2_column_ff;
   logic [sdu_pkg::LINE_W-1:0]   s2_line_ff;
   logic                         s2_inrange_ff;
   logic [AW-1:0]                s2_addr_ff;
   logic                         fwd_hit_ff;
   logic [sdu_pkg::PIXEL_W-1:0]  fwd_data_ff;
   logic [sdu_pkg::PIXEL_W-1:0]  s2_shadow;
   logic                         s2_in_group;
   logic                         s2_changed;
   logic                         s2_emits;
   logic                         s2_leave;
   logic [sdu_pkg::LIMIT_W-1:0]  end_sum;
   logic [sdu_pkg::COLUMN_W-1:0] new_end;

   // Group tracking
   logic                         group_open_ff, group_open_in;
   logic [sdu_pkg::COLUMN_W-1:0] group_end_ff, group_end_in;

   // Memory and sequencer links
   logic [sdu_pkg::PIXEL_W-1:0]  rd_data;
   logic                         clearing;
   logic                         mem_wr_en;
   logic                         em_free;
   logic                         em_load_en;
   sdu_pkg::burst_type           em_load;

   // Run length register
   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff <= sdu_pkg::RUN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         run_length_ff <= csr_wr_data;
      end
   end

   // Stage 1 address and range check
   assign s1_inrange = ({1'b0, s1_column_ff} < WIDTH_LIM) &&
                       (sdu_pkg::LIMIT_W'(s1_line_ff) < HEIGHT_LIM);
   assign s1_addr    = AW'(AW'(s1_line_ff) * AW'(PANEL_WIDTH)) + AW'(s1_column_ff);

   // Pipeline flow
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_leave);
   assign req_stall = clearing || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_leave) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // Hold payloads; capture a write to the entry being read this cycle
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_pixel_ff  <= req_pixel;
         s1_column_ff <= req_column;
         s1_line_ff   <= req_line;
      end
      if (s1_adv) begin
         s2_pixel_ff   <= s1_pixel_ff;
         s2_column_ff  <= s1_column_ff;
         s2_line_ff    <= s1_line_ff;
         s2_inrange_ff <= s1_inrange;
         s2_addr_ff    <= s1_addr;
         fwd_hit_ff    <= mem_wr_en && (s2_addr_ff == s1_addr);
         fwd_data_ff   <= s2_pixel_ff;
      end
   end

   // Stage 2 decision
   assign s2_shadow   = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign s2_in_group = group_open_ff && !(s2_column_ff > group_end_ff);
   assign s2_changed  = s2_shadow != s2_pixel_ff;
   assign s2_emits    = s2_inrange_ff && (s2_in_group || s2_changed);
   assign s2_leave    = s2_valid_ff && (!s2_emits || em_free);
   assign em_load_en  = s2_leave && s2_emits;
   assign mem_wr_en   = em_load_en;

   // Group end limited to the last column
   assign end_sum = sdu_pkg::LIMIT_W'(s2_column_ff) + sdu_pkg::LIMIT_W'(run_length_ff);
   assign new_end = (end_sum > LAST_COL) ? LAST_COL[sdu_pkg::COLUMN_W-1:0]
                                         : end_sum[sdu_pkg::COLUMN_W-1:0];

   // Update group state as each item leaves stage 2
   always_comb begin
      group_open_in = group_open_ff;
      group_end_in  = group_end_ff;
      if (s2_leave && s2_inrange_ff) begin
         if (s2_in_group) begin
            group_open_in = (s2_column_ff != group_end_ff);
         end else if (s2_changed) begin
            group_end_in  = new_end;
            group_open_in = (s2_column_ff != new_end);
         end else begin
            group_open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_open_ff <= 1'b0;
         group_end_ff  <= '0;
      end else begin
         group_open_ff <= group_open_in;
         group_end_ff  <= group_end_in;
      end
   end

   always_comb begin
      em_load.full      = !s2_in_group;
      em_load.line      = s2_line_ff;
      em_load.column    = s2_column_ff;
      em_load.group_end = new_end;
      em_load.pixel     = s2_pixel_ff;
   end

   sdu_shadow_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_shadow_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (s1_adv),
      .rd_addr  (s1_addr),
      .rd_data  (rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (s2_addr_ff),
      .wr_data  (s2_pixel_ff),
      .clearing (clearing)
   );

   sdu_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load_en        (em_load_en),
      .load           (em_load),
      .free           (em_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_command (rsp_is_command),
      .rsp_bus_value  (rsp_bus_value),
      .rsp_last       (rsp_last)
   );

endmodule

>>> rtl/sdu_checker.sv
// Port-level checks for the shadow-difference display updater, bound to the
// top level. Uses sdu_pkg for field widths.
`timescale 1ns / 1ps

module sdu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_is_command,
   input logic [sdu_pkg::BUS_W-1:0]    rsp_bus_value,
   input logic                         rsp_last
);

   // Reset empties the output and starts the memory sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_stall))
      else $error("output valid or input open right after reset");

   // A burst continues without gaps until its last write
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("burst broke off before its last write");

   // The final write of an item is pixel data, never a command
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !rsp_is_command)
      else $error("command write marked as last");

   // Command words carry a zero high byte
   a_cmd_high_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_command) |-> (rsp_bus_value[15:8] == 8'h00))
      else $error("command word with nonzero high byte");

   // A stalled write holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_bus_value)))
      else $error("stalled output changed");

endmodule

bind shadow_diff_display_updater sdu_checker u_sdu_checker (.*);

>>> bench/tb_shadow_diff_display_updater.sv
// Self-checking bench for shadow_diff_display_updater: random pixel stream with
// bus write prediction. Depends on sdu_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_shadow_diff_display_updater;

   localparam int PANEL_W = 800;
   localparam int PANEL_H = 480;

   typedef struct packed {
      logic [sdu_pkg::PIXEL_W-1:0]  pixel;
      logic [sdu_pkg::COLUMN_W-1:0] column;
      logic [sdu_pkg::LINE_W-1:0]   line;
   } pixel_item_type;

   typedef struct packed {
      logic                      is_command;
      logic [sdu_pkg::BUS_W-1:0] bus_value;
      logic                      last;
   } bus_write_type;

   // Clock, reset and every block input start at known values
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [sdu_pkg::PIXEL_W-1:0]  req_pixel = '0;
   logic [sdu_pkg::COLUMN_W-1:0] req_column = '0;
   logic [sdu_pkg::LINE_W-1:0]   req_line = '0;
   logic rsp_stall = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [sdu_pkg::COLUMN_W-1:0] csr_wr_data = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic                      rsp_is_command;
   logic [sdu_pkg::BUS_W-1:0] rsp_bus_value;
   logic                      rsp_last;

   // Stimulus queue and expected bus writes
   pixel_item_type pending_pixels[$];
   bus_write_type  expected_writes[$];

   // Predictor state: panel shadow copy, open group and run length
   bit   [15:0] shadow_img [PANEL_W*PANEL_H];
   logic [9:0]  grp_end = '0;
   logic        grp_open = 1'b0;
   logic [9:0]  run_len = sdu_pkg::RUN_LENGTH_RESET;

   // Idling control and bookkeeping
   logic        idle_on = 1'b1;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic        long_hold_done = 1'b0;
   int unsigned writes_seen = 0;
   int unsigned pixels_taken = 0;
   int unsigned pixels_outside = 0;
   int unsigned groups_opened = 0;
   int unsigned settings_used = 0;
   int unsigned fail_count = 0;

   shadow_diff_display_updater #(
      .PANEL_WIDTH (PANEL_W),
      .PANEL_HEIGHT(PANEL_H)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .req_column    (req_column),
      .req_line      (req_line),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_command(rsp_is_command),
      .rsp_bus_value (rsp_bus_value),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Append one bus write to the expected stream
   function automatic void push_write(logic is_cmd, logic [15:0] value);
      bus_write_type w;
      w.is_command = is_cmd;
      w.bus_value  = value;
      w.last       = 1'b0;
      expected_writes.push_back(w);
   endfunction

   // Work out the bus writes one accepted pixel causes and update the shadow copy
   function automatic void predict_writes(logic [15:0] pix, logic [9:0] col, logic [8:0] lin);
      int unsigned addr;
      int unsigned gend;
      if (col >= PANEL_W || lin >= PANEL_H) begin
         pixels_outside++;
         return;
      end
      addr = lin * PANEL_W + col;
      // close a group the pixel has run past
      if (grp_open && col > grp_end)
         grp_open = 1'b0;
      if (!grp_open) begin
         if (shadow_img[addr] == pix)
            return;
         gend = col + run_len;
         if (gend > PANEL_W - 1)
            gend = PANEL_W - 1;
         grp_end  = gend[9:0];
         grp_open = 1'b1;
         groups_opened++;
         push_write(1'b1, {8'h00, sdu_pkg::CMD_LINE_START});
         push_write(1'b0, {7'd0, lin});
         push_write(1'b1, {8'h00, sdu_pkg::CMD_COL_START});
         push_write(1'b0, {6'd0, col});
         push_write(1'b1, {8'h00, sdu_pkg::CMD_LINE_END});
         push_write(1'b0, {7'd0, lin});
         push_write(1'b1, {8'h00, sdu_pkg::CMD_COL_END});
         push_write(1'b0, {6'd0, grp_end});
         push_write(1'b1, {8'h00, sdu_pkg::CMD_MEM_WRITE});
      end
      push_write(1'b0, pix);
      shadow_img[addr] = pix;
      if (col == grp_end)
         grp_open = 1'b0;
      expected_writes[expected_writes.size()-1].last = 1'b1;
   endfunction

   // Driver: offer pending pixels, hold a stalled item, idle in random bursts
   always @(posedge clock) begin : drive_pixels
      pixel_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idle_on && pending_pixels.size() != 0 && $urandom_range(0, 7) == 0) begin
            send_gap  <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            nxt = pending_pixels.pop_front();
            req_valid  <= 1'b1;
            req_pixel  <= nxt.pixel;
            req_column <= nxt.column;
            req_line   <= nxt.line;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts plus one long hold to back the block up
   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && writes_seen >= 200) begin
         long_hold_done <= 1'b1;
         hold_left      <= 400;
         rsp_stall      <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: track register writes, predict on accept, check each bus write
   always @(posedge clock) begin : watch_ports
      bus_write_type want;
      if (!reset) begin
         if (csr_wr_en)
            run_len = csr_wr_data;
         if (req_valid && !req_stall) begin
            pixels_taken++;
            predict_writes(req_pixel, req_column, req_line);
         end
         if (rsp_valid && !rsp_stall) begin
            writes_seen <= writes_seen + 1;
            if (expected_writes.size() == 0) begin
               $error("bus write with nothing expected: is_command %0d bus_value %h last %0d",
                      rsp_is_command, rsp_bus_value, rsp_last);
               fail_count++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_is_command !== want.is_command) begin
                  $error("is_command: expected %0d, actual %0d", want.is_command, rsp_is_command);
                  fail_count++;
               end
               if (rsp_bus_value !== want.bus_value) begin
                  $error("bus_value: expected %h, actual %h", want.bus_value, rsp_bus_value);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Queue one pixel; call only at a falling edge
   task automatic queue_pixel(logic [15:0] pix, logic [9:0] col, logic [8:0] lin);
      pixel_item_type it;
      it.pixel  = pix;
      it.column = col;
      it.line   = lin;
      pending_pixels.push_back(it);
   endtask

   // Wait until every pixel is taken and every write has come, then let the pipe settle
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_run_length(logic [9:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h1234;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] pick_line();
      case ($urandom_range(0, 3))
         0: return 9'($urandom_range(0, 3));
         1: return 9'd479;
         2: return 9'($urandom_range(256, 300));
         default: return 9'($urandom_range(0, PANEL_H - 1));
      endcase
   endfunction

   // Mostly ascending runs along a line from a small palette, some noise anywhere
   task automatic queue_random_pixels(int unsigned want);
      int unsigned placed;
      int unsigned seg_len;
      int unsigned k;
      int unsigned pick;
      logic [9:0]  col;
      logic [8:0]  lin;
      logic [15:0] pix;
      placed = 0;
      while (placed < want) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            col = 10'($urandom);
            lin = 9'($urandom);
            pix = 16'($urandom);
            queue_pixel(pix, col, lin);
            if (col < PANEL_W && lin < PANEL_H)
               placed++;
         end else begin
            lin = pick_line();
            col = (pick == 1) ? 10'($urandom_range(760, PANEL_W - 1))
                              : 10'($urandom_range(0, PANEL_W - 1));
            seg_len = $urandom_range(1, 30);
            for (k = 0; k < seg_len && col < PANEL_W && placed < want; k++) begin
               queue_pixel(pick_pixel(), col, lin);
               placed++;
               col = col + 10'($urandom_range(1, 3));
            end
         end
      end
   endtask

   // Stimulus: directed corners, then random phases at several run lengths
   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset run length of 40
      queue_pixel(16'h0000, 10'd0, 9'd0);        // unchanged, no group: silent
      queue_pixel(16'hFFFF, 10'd0, 9'd0);        // opens group ending at 40
      queue_pixel(16'h0000, 10'd1, 9'd0);        // inside group, sent though unchanged
      queue_pixel(16'hA5A5, 10'd40, 9'd0);       // group end closes it
      queue_pixel(16'h0000, 10'd41, 9'd0);       // unchanged again: silent
      queue_pixel(16'h5A5A, 10'd790, 9'd0);      // end limited to last column
      queue_pixel(16'h0001, 10'd799, 9'd0);
      queue_pixel(16'h8000, 10'd799, 9'd1);      // one-pixel group at last column
      queue_pixel(16'h1234, 10'd100, 9'd479);
      queue_pixel(16'h0001, 10'd200, 9'd479);    // past group end: close, reopen
      queue_pixel(16'h0000, 10'd210, 9'd5);      // line change while open
      queue_pixel(16'hFFFF, 10'd800, 9'd3);      // outside panel: ignored
      queue_pixel(16'hFFFF, 10'd1023, 9'd3);
      queue_pixel(16'hFFFF, 10'd5, 9'd480);
      queue_pixel(16'hFFFF, 10'd5, 9'd511);
      queue_pixel(16'h0007, 10'd240, 9'd5);      // closes the reopened group
      wait_drained();

      // Run length zero: every changed pixel is a group of its own
      write_run_length(10'd0);
      queue_pixel(16'h00FF, 10'd10, 9'd10);
      queue_pixel(16'hFF00, 10'd11, 9'd10);
      queue_pixel(16'h0000, 10'd12, 9'd10);
      wait_drained();

      // Largest run length: group spans to the last column
      write_run_length(10'd799);
      queue_pixel(16'h0F0F, 10'd0, 9'd20);
      queue_pixel(16'h0000, 10'd512, 9'd20);
      queue_pixel(16'hF0F0, 10'd799, 9'd20);
      wait_drained();

      write_run_length(10'($urandom_range(2, 50)));
      queue_random_pixels(75);
      wait_drained();

      write_run_length(10'd0);
      queue_random_pixels(75);
      wait_drained();

      // No idling from here on
      @(posedge clock);
      idle_on <= 1'b0;
      @(negedge clock);
      write_run_length(10'($urandom_range(100, 799)));
      queue_random_pixels(75);
      wait_drained();

      write_run_length(10'd799);
      queue_random_pixels(75);
      wait_drained();

      $display("Pixels sent: %0d (%0d outside the panel), groups opened: %0d",
               pixels_taken, pixels_outside, groups_opened);
      $display("Bus writes checked: %0d across %0d run length settings plus the reset one",
               writes_seen, settings_used);
      if (fail_count == 0)
         $display("[shadow_diff_display_updater] OK");
      else
         $display("[shadow_diff_display_updater] ERROR");
      $finish;
   end

   // Watchdog: shadow clear sweep plus the whole run, several times over
   initial begin : watchdog
      #(64'd20_000_000);
      $display("[shadow_diff_display_updater] ERROR");
      $finish;
   end

endmodule
